/* rtl/hlb_pkg.sv */
// Shared types and constants for the HD44780 LCD bus sequencer.
// Holds the phase enum, the queued tick item, the result record and the config record.
// No dependencies.
package hlb_pkg;

    // Width of the strobe high-time counter
    localparam int TICK_W = 16;
    localparam int STROBE_W = 16;
    // Compare width wide enough for counter + 1 and for the strobe length
    localparam int CMP_W = ((TICK_W > STROBE_W) ? TICK_W : STROBE_W) + 1;

    localparam logic [7:0] BUSY_BIT = 8'h80;
    localparam logic [7:0] HI_NIB   = 8'hF0;
    localparam logic [7:0] LO_NIB   = 8'h0F;

    // Configuration register indexes
    localparam logic CFG_BUS_EIGHT_BIT = 1'b0;
    localparam logic CFG_STROBE_TICKS  = 1'b1;

    localparam logic                RST_BUS_EIGHT_BIT = 1'b1;
    localparam logic [STROBE_W-1:0] RST_STROBE_TICKS  = STROBE_W'(1000);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_RD1H = 4'd1,
        PH_RD1L = 4'd2,
        PH_RD2H = 4'd3,
        PH_RD2L = 4'd4,
        PH_WR1H = 4'd5,
        PH_WR1L = 4'd6,
        PH_WR2H = 4'd7,
        PH_WR2L = 4'd8
    } t_phase;

    // One clock tick as classified by the front end
    typedef struct packed {
        logic       has_req;
        logic       is_data;
        logic [7:0] req_byte;
        logic [7:0] pins;
    } t_item;

    // Pin levels and status produced for one tick
    typedef struct packed {
        logic       enable;
        logic       register_select;
        logic       read_not_write;
        logic [7:0] data_out;
        logic       data_drive;
        logic       ready_res;
        logic [7:0] status_byte;
    } t_result;

    typedef struct packed {
        logic                bus_eight_bit;
        logic [STROBE_W-1:0] strobe_ticks;
    } t_cfg;

endpackage

/* rtl/hlb_queue.sv */
// Two-entry tick queue between the front end and the bus sequencer.
// Depends on hlb_pkg for the t_item record.
module hlb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hlb_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output hlb_pkg::t_item o_item
);

    hlb_pkg::t_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_item     = r_mem[r_rd_ptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/hlb_seq.sv */
// Bus sequencer back end: steps the busy-poll / write state machine once per tick
// and holds the tick's result in an output register. Depends on hlb_pkg.
module hlb_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hlb_pkg::t_cfg   i_cfg,
    input  logic            i_item_valid,
    input  hlb_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output hlb_pkg::t_result o_res
);

    hlb_pkg::t_phase r_phase, n_phase;
    logic [hlb_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [7:0] r_pending_byte, n_pending_byte;
    logic       r_pending_is_data, n_pending_is_data;
    logic [3:0] r_rd_hi, n_rd_hi;
    logic [7:0] r_last_status, n_last_status;
    logic       r_res_valid;
    hlb_pkg::t_result r_res, n_res;

    logic                      w_step;
    logic                      w_done;
    logic [hlb_pkg::CMP_W-1:0] w_limit;
    logic [hlb_pkg::CMP_W-1:0] w_inc;
    logic [7:0]                w_status_rd2;

    // Step when a tick is queued and the output slot is free or draining
    assign w_step      = i_item_valid && (!r_res_valid || i_res_ready);
    assign o_pop       = w_step;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Strobe end: last high tick reached or counter saturated
    always_comb begin
        w_limit = (i_cfg.strobe_ticks == '0) ? hlb_pkg::CMP_W'(1)
                                              : hlb_pkg::CMP_W'(i_cfg.strobe_ticks);
        w_inc   = hlb_pkg::CMP_W'(r_tick) + hlb_pkg::CMP_W'(1);
        w_done  = (w_inc >= w_limit) || (r_tick == '1);
    end

    assign w_status_rd2 = {r_rd_hi, i_item.pins[7:4]};

    // Next state
    always_comb begin
        n_phase           = r_phase;
        n_tick            = r_tick;
        n_pending_byte    = r_pending_byte;
        n_pending_is_data = r_pending_is_data;
        n_rd_hi           = r_rd_hi;
        n_last_status     = r_last_status;
        unique case (r_phase)
            hlb_pkg::PH_IDLE: begin
                if (i_item.has_req) begin
                    n_pending_byte    = i_item.req_byte;
                    n_pending_is_data = i_item.is_data;
                    n_tick            = '0;
                    n_phase           = hlb_pkg::PH_RD1H;
                end
            end
            hlb_pkg::PH_RD1H: begin
                n_tick = w_done ? '0 : r_tick + 1'b1;
                if (w_done) begin
                    if (i_cfg.bus_eight_bit) begin
                        n_last_status = i_item.pins;
                    end else begin
                        n_rd_hi = i_item.pins[7:4];
                    end
                    n_phase = hlb_pkg::PH_RD1L;
                end
            end
            hlb_pkg::PH_RD1L: begin
                n_tick = '0;
                if (!i_cfg.bus_eight_bit) begin
                    n_phase = hlb_pkg::PH_RD2H;
                end else if ((r_last_status & hlb_pkg::BUSY_BIT) != 8'h00) begin
                    n_phase = hlb_pkg::PH_RD1H;
                end else begin
                    n_phase = hlb_pkg::PH_WR1H;
                end
            end
            hlb_pkg::PH_RD2H: begin
                n_tick = w_done ? '0 : r_tick + 1'b1;
                if (w_done) begin
                    n_last_status = w_status_rd2;
                    n_phase       = hlb_pkg::PH_RD2L;
                end
            end
            hlb_pkg::PH_RD2L: begin
                n_tick  = '0;
                n_phase = ((r_last_status & hlb_pkg::BUSY_BIT) != 8'h00) ? hlb_pkg::PH_RD1H
                                                                          : hlb_pkg::PH_WR1H;
            end
            hlb_pkg::PH_WR1H, hlb_pkg::PH_WR2H: begin
                n_tick = w_done ? '0 : r_tick + 1'b1;
                if (w_done) begin
                    n_phase = (r_phase == hlb_pkg::PH_WR1H) ? hlb_pkg::PH_WR1L
                                                            : hlb_pkg::PH_WR2L;
                end
            end
            hlb_pkg::PH_WR1L: begin
                n_tick  = '0;
                n_phase = i_cfg.bus_eight_bit ? hlb_pkg::PH_IDLE : hlb_pkg::PH_WR2H;
            end
            hlb_pkg::PH_WR2L: begin
                n_tick  = '0;
                n_phase = hlb_pkg::PH_IDLE;
            end
            default: begin
                n_tick  = '0;
                n_phase = hlb_pkg::PH_IDLE;
            end
        endcase
    end

    // Outputs for this tick, from the phase at its start
    always_comb begin
        n_res                 = '0;
        n_res.data_drive      = 1'b1;
        n_res.status_byte     = n_last_status;
        unique case (r_phase)
            hlb_pkg::PH_IDLE: begin
                n_res.ready_res = i_item.has_req;
            end
            hlb_pkg::PH_RD1H, hlb_pkg::PH_RD2H: begin
                n_res.enable         = 1'b1;
                n_res.read_not_write = 1'b1;
                n_res.data_drive     = 1'b0;
            end
            hlb_pkg::PH_RD1L, hlb_pkg::PH_RD2L: begin
                n_res.read_not_write = 1'b1;
                n_res.data_drive     = 1'b0;
            end
            hlb_pkg::PH_WR1H, hlb_pkg::PH_WR1L: begin
                n_res.enable          = (r_phase == hlb_pkg::PH_WR1H);
                n_res.register_select = r_pending_is_data;
                n_res.data_out        = i_cfg.bus_eight_bit ? r_pending_byte
                                                            : (r_pending_byte & hlb_pkg::HI_NIB);
            end
            hlb_pkg::PH_WR2H, hlb_pkg::PH_WR2L: begin
                n_res.enable          = (r_phase == hlb_pkg::PH_WR2H);
                n_res.register_select = r_pending_is_data;
                n_res.data_out        = {r_pending_byte[3:0], 4'h0};
            end
            default: begin
                n_res.data_drive = 1'b1;
            end
        endcase
    end

    // Hold sequencer state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= hlb_pkg::PH_IDLE;
            r_tick            <= '0;
            r_pending_byte    <= 8'h00;
            r_pending_is_data <= 1'b0;
            r_rd_hi           <= 4'h0;
            r_last_status     <= 8'h00;
        end else if (w_step) begin
            r_phase           <= n_phase;
            r_tick            <= n_tick;
            r_pending_byte    <= n_pending_byte;
            r_pending_is_data <= n_pending_is_data;
            r_rd_hi           <= n_rd_hi;
            r_last_status     <= n_last_status;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_step) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= n_res;
        end
    end

endmodule

/* rtl/hd44780_lcd_bus_sequencer.sv */
// HD44780 LCD bus sequencer: one input transaction per clock tick, one result per tick.
// A tick is queued, then its result is registered in the output register once that is free.
// Throughput: one tick per cycle unless the output stalls; one sequencer step per popped tick.
// Reset (synchronous, active low): phase idle, counters and status zero, 8-bit bus,
// strobe length 1000 ticks, queue and output register empty.
// Depends on hlb_pkg, hlb_queue and hlb_seq.
module hd44780_lcd_bus_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_request_valid,
    input  logic       i_request_is_data,
    input  logic [7:0] i_request_byte,
    input  logic [7:0] i_pins_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_enable,
    output logic       o_register_select,
    output logic       o_read_not_write,
    output logic [7:0] o_data_out,
    output logic       o_data_drive,
    output logic       o_ready_res,
    output logic [7:0] o_status_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [hlb_pkg::STROBE_W-1:0] i_cfg_data
);

    hlb_pkg::t_cfg    r_cfg;
    hlb_pkg::t_item   w_item;
    hlb_pkg::t_item   w_head;
    hlb_pkg::t_result w_res;
    logic w_full;
    logic w_nonempty;
    logic w_pop;
    logic w_push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_eight_bit <= hlb_pkg::RST_BUS_EIGHT_BIT;
            r_cfg.strobe_ticks  <= hlb_pkg::RST_STROBE_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hlb_pkg::CFG_BUS_EIGHT_BIT: r_cfg.bus_eight_bit <= i_cfg_data[0];
                hlb_pkg::CFG_STROBE_TICKS:  r_cfg.strobe_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: classify the tick and push it into the queue
    assign w_item.has_req  = i_request_valid;
    assign w_item.is_data  = i_request_is_data;
    assign w_item.req_byte = i_request_byte;
    assign w_item.pins     = i_pins_in;
    assign o_ready         = !w_full;
    assign w_push          = i_valid && !w_full;

    hlb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_head)
    );

    hlb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item_valid(w_nonempty),
        .i_item      (w_head),
        .o_pop       (w_pop),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (w_res)
    );

    assign o_enable          = w_res.enable;
    assign o_register_select = w_res.register_select;
    assign o_read_not_write  = w_res.read_not_write;
    assign o_data_out        = w_res.data_out;
    assign o_data_drive      = w_res.data_drive;
    assign o_ready_res       = w_res.ready_res;
    assign o_status_byte     = w_res.status_byte;

endmodule
